[hdl/mpqs_pkg.sv]
// Shared types and constants for the scanning max-priority queue.
package mpqs_pkg;

  localparam int PRIO_W = 10;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 8;
  localparam int STAT_W = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_ADJUST = 2'd3;

  typedef struct packed {
    logic              action;
    logic [PRIO_W-1:0] prio_in;
    logic [TAG_W-1:0]  tag_in;
  } mpqs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] prio_out;
    logic [TAG_W-1:0]  tag_out;
    logic [OCC_W-1:0]  occupancy;
  } mpqs_out_t;

  typedef struct packed {
    logic              load;
    logic              sweep;
    logic [1:0]        mode;
    logic              ins_wr;
    logic              emit;
    logic [STAT_W-1:0] status;
  } mpqs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last;
  } mpqs_sts_t;

endpackage

[hdl/mpqs_ctrl.sv]
// Sequencer for the clear, insert, find and adjust sweeps.
module mpqs_ctrl
  import mpqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      action,
  input  mpqs_sts_t sts,
  output logic      busy,
  output mpqs_cmd_t cmd
);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_INS_WR = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_ADJ    = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.sweep = 1'b1;
        cmd.mode  = MODE_CLEAR;
        if (sts.last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (action == ACT_INSERT) begin
            if (sts.full) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_FULL;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            if (sts.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              state_nxt = S_FIND;
            end
          end
        end
      end
      S_INS: begin
        cmd.sweep = 1'b1;
        cmd.mode  = MODE_INSERT;
        if (sts.last) state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = STAT_INSERTED;
        state_nxt  = S_IDLE;
      end
      S_FIND: begin
        cmd.sweep = 1'b1;
        cmd.mode  = MODE_FIND;
        if (sts.last) state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.sweep = 1'b1;
        cmd.mode  = MODE_ADJUST;
        if (sts.last) begin
          cmd.emit   = 1'b1;
          cmd.status = STAT_REMOVED;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hdl/mpqs_dp.sv]
// Entry memory, sweep counter, best/free trackers and result register.
module mpqs_dp
  import mpqs_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mpqs_cmd_t cmd,
  input  mpqs_in_t  in_data,
  output mpqs_sts_t sts,
  output logic      out_valid,
  output mpqs_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic              valid;
    logic [AW-1:0]     rank;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } ent_t;

  ent_t mem [CAPACITY];
  ent_t rd_r;
  ent_t wd;
  logic we;
  logic [AW-1:0] wa, ra, proc_idx;
  logic proc_en;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] count_r, count_nxt;
  mpqs_in_t in_r;

  logic              best_vld_r, free_vld_r;
  logic [AW-1:0]     best_idx_r, free_idx_r;
  logic [AW-1:0]     best_rank_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic [TAG_W-1:0]  best_tag_r;
  logic              better;

  logic      out_valid_r;
  mpqs_out_t out_r;

  // sweep: read index k at step k, process it at step k+1
  always_comb begin
    if (!cmd.sweep || cnt_r == CW'(CAPACITY)) cnt_nxt = '0;
    else                                      cnt_nxt = cnt_r + 1'b1;
  end

  assign ra       = (cnt_r < CW'(CAPACITY)) ? cnt_r[AW-1:0] : '0;
  assign proc_idx = AW'(cnt_r - 1'b1);
  assign proc_en  = cmd.sweep && (cnt_r != '0) && (cmd.mode != MODE_CLEAR);

  assign better = rd_r.valid &&
                  (!best_vld_r || (rd_r.prio > best_prio_r) ||
                   ((rd_r.prio == best_prio_r) && (rd_r.rank < best_rank_r)));

  always_comb begin
    we = 1'b0;
    wa = proc_idx;
    wd = rd_r;
    if (cmd.ins_wr) begin
      we       = 1'b1;
      wa       = free_idx_r;
      wd.valid = 1'b1;
      wd.rank  = '0;
      wd.prio  = in_r.prio_in;
      wd.tag   = in_r.tag_in;
    end else if (cmd.sweep) begin
      case (cmd.mode)
        MODE_CLEAR: begin
          we = (cnt_r < CW'(CAPACITY));
          wa = ra;
          wd = '0;
        end
        MODE_INSERT: begin
          we      = proc_en && rd_r.valid;
          wd.rank = rd_r.rank + 1'b1;
        end
        MODE_ADJUST: begin
          we = proc_en;
          if (proc_idx == best_idx_r) begin
            wd.valid = 1'b0;
          end else if (rd_r.valid && (rd_r.rank > best_rank_r)) begin
            wd.rank = rd_r.rank - 1'b1;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.emit && cmd.status == STAT_INSERTED)     count_nxt = count_r + 1'b1;
    else if (cmd.emit && cmd.status == STAT_REMOVED) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      best_vld_r  <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        best_vld_r <= 1'b0;
        free_vld_r <= 1'b0;
      end else if (proc_en && cmd.mode == MODE_FIND && better) begin
        best_vld_r <= 1'b1;
      end else if (proc_en && cmd.mode == MODE_INSERT && !rd_r.valid && !free_vld_r) begin
        free_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (proc_en && cmd.mode == MODE_FIND && better) begin
      best_idx_r  <= proc_idx;
      best_rank_r <= rd_r.rank;
      best_prio_r <= rd_r.prio;
      best_tag_r  <= rd_r.tag;
    end
    if (proc_en && cmd.mode == MODE_INSERT && !rd_r.valid && !free_vld_r) begin
      free_idx_r <= proc_idx;
    end
    if (cmd.emit) begin
      out_r.status    <= cmd.status;
      out_r.prio_out  <= (cmd.status == STAT_REMOVED) ? best_prio_r : '0;
      out_r.tag_out   <= (cmd.status == STAT_REMOVED) ? best_tag_r : '0;
      out_r.occupancy <= OCC_W'(count_nxt);
    end
  end

  assign sts.full  = (count_r == CW'(CAPACITY));
  assign sts.empty = (count_r == '0);
  assign sts.last  = cmd.sweep && (cnt_r == CW'(CAPACITY));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> (free_vld_r && !sts.full))
    else $error("insert write without a free slot");

  a_rem_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.status == STAT_REMOVED) |-> best_vld_r)
    else $error("remove without a selected entry");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != STAT_REMOVED) |->
      (out_r.prio_out == '0 && out_r.tag_out == '0))
    else $error("nonzero payload on non-remove result");

endmodule

[hdl/max_priority_queue_scan.sv]
// Top level of the scanning max-priority queue.
// Holds up to CAPACITY (priority, tag) entries in one unsorted memory with an
// age rank per entry; ties go to the newest entry. After reset a clearing
// sweep runs with busy high. An insert into a full queue or a remove from an
// empty one is answered in the cycle after the accept and busy stays low. A
// good insert runs one rank-update sweep of the single-port-read memory and
// then writes the entry; a good remove runs a max-search sweep, then a sweep
// that frees the slot and closes the rank gap. Each transaction gives exactly
// one result, held on out_data for one cycle while out_valid is high; it
// cannot be stalled.
module max_priority_queue_scan
  import mpqs_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mpqs_in_t  in_data,
  output logic      out_valid,
  output mpqs_out_t out_data
);

  mpqs_cmd_t cmd;
  mpqs_sts_t sts;

  mpqs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  mpqs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[bench/max_priority_queue_scan_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the scanning max-priority queue.
module max_priority_queue_scan_tb;
  import mpqs_pkg::*;

  localparam int QUEUE_DEPTH = 128;
  localparam int TOTAL_ITEMS = 950;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

  typedef struct {
    bit       hold;
    mpqs_in_t req;
    int       idle_pct;
  } stim_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mpqs_in_t  in_data = '0;
  logic      out_valid;
  mpqs_out_t out_data;

  stim_t     stim_q[$];
  mpqs_out_t outcome_q[$];
  logic      handoff = 1'b0;
  int        gap_left = 0;
  int        cycle_count = 0;
  int        errors = 0;

  logic [PRIO_W-1:0] held_prio[QUEUE_DEPTH];
  logic [TAG_W-1:0]  held_tag[QUEUE_DEPTH];
  int                held_age[QUEUE_DEPTH];
  bit                held_live[QUEUE_DEPTH];
  int                held_count = 0;

  int gen_occ = 0;
  int n_items = 0;
  int n_inserted = 0, n_full = 0, n_removed = 0, n_empty = 0, n_ties = 0, peak_occ = 0;

  max_priority_queue_scan #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mpqs_out_t queue_outcome(input mpqs_in_t req);
    mpqs_out_t res;
    int slot;
    int best;
    int same;
    res = '0;
    if (req.action == ACT_INSERT) begin
      slot = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (!held_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        res.status = STAT_FULL;
        n_full++;
      end else begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (held_live[i]) held_age[i]++;
        held_prio[slot] = req.prio_in;
        held_tag[slot] = req.tag_in;
        held_age[slot] = 0;
        held_live[slot] = 1'b1;
        held_count++;
        res.status = STAT_INSERTED;
        n_inserted++;
      end
    end else begin
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (held_live[i] && (best < 0 || held_prio[i] > held_prio[best] ||
            (held_prio[i] == held_prio[best] && held_age[i] < held_age[best])))
          best = i;
      if (best < 0) begin
        res.status = STAT_EMPTY;
        n_empty++;
      end else begin
        same = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (held_live[i] && held_prio[i] == held_prio[best]) same++;
        if (same > 1) n_ties++;
        res.status = STAT_REMOVED;
        res.prio_out = held_prio[best];
        res.tag_out = held_tag[best];
        held_live[best] = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (held_live[i] && held_age[i] > held_age[best]) held_age[i]--;
        held_count--;
        n_removed++;
      end
    end
    res.occupancy = OCC_W'(held_count);
    if (held_count > peak_occ) peak_occ = held_count;
    return res;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, seen);
      errors++;
    end
  endtask

  task automatic add_hold();
    stim_t s;
    s.hold = 1'b1;
    s.req = '0;
    s.idle_pct = 0;
    stim_q.push_back(s);
  endtask

  task automatic add_item(input logic act, input int pr, input int tg);
    stim_t s;
    if (n_items == TOTAL_ITEMS / 3 || n_items == 2 * TOTAL_ITEMS / 3) add_hold();
    s.hold = 1'b0;
    s.req.action = act;
    s.req.prio_in = PRIO_W'(pr);
    s.req.tag_in = TAG_W'(tg);
    s.idle_pct = (n_items < TOTAL_ITEMS / 3) ? 33 : (n_items < 2 * TOTAL_ITEMS / 3) ? 71 : 0;
    stim_q.push_back(s);
    n_items++;
    if (act == ACT_INSERT && gen_occ < QUEUE_DEPTH) gen_occ++;
    if (act == ACT_REMOVE && gen_occ > 0) gen_occ--;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : drive
    stim_t head;
    stim_t done;
    logic  go;
    if (rst_n && (!start || handoff)) begin
      go = 1'b0;
      if (start) begin
        done = stim_q.pop_front();
        if ($urandom_range(0, 99) < done.idle_pct)
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SETTLE_CYCLES)
                                                 : $urandom_range(1, 3);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (stim_q.size() != 0) begin
        head = stim_q[0];
        if (head.hold) begin
          if (outcome_q.size() == 0) head = stim_q.pop_front();
        end else begin
          go = 1'b1;
          in_data <= head.req;
        end
      end
      start <= go;
    end
  end

  // monitor: accepted transactions and results sampled on the rising edge
  always @(posedge clk) begin : monitor
    mpqs_out_t want;
    if (!rst_n) begin
      handoff <= 1'b0;
    end else begin
      if (out_valid !== 1'b0) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with none expected, got %h", $time, out_data);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", 32'(want.status), 32'(out_data.status));
          compare_field("prio_out", 32'(want.prio_out), 32'(out_data.prio_out));
          compare_field("tag_out", 32'(want.tag_out), 32'(out_data.tag_out));
          compare_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        end
      end
      if (start && busy === 1'b0) outcome_q.push_back(queue_outcome(in_data));
      handoff <= start && busy === 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               outcome_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    burst_t kind;
    int     bursts;
    int     pmode;
    int     pbase;
    int     bias;
    int     left;
    int     pr;
    logic   act;

    // directed: empty queue, extreme fields, three-way tie, slot reuse
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_INSERT, 0, 16'h0000);
    add_item(ACT_INSERT, 1023, 16'hFFFF);
    add_item(ACT_INSERT, 1023, 16'h1234);
    add_item(ACT_INSERT, 512, 16'hAAAA);
    add_item(ACT_INSERT, 1023, 16'h5555);
    add_item(ACT_REMOVE, 1023, 16'hFFFF);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_INSERT, 0, 16'h5A5A);
    add_item(ACT_INSERT, 341, 16'h0F0F);
    add_item(ACT_INSERT, 682, 16'hF0F0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_item(ACT_REMOVE, 0, 0);
    add_hold();

    // random bursts; start with a fill past full and a drain past empty
    bursts = 0;
    while (n_items < TOTAL_ITEMS) begin
      if (bursts == 0) begin
        kind = BURST_FILL;
      end else if (bursts == 1) begin
        kind = BURST_DRAIN;
      end else begin
        left = $urandom_range(0, 19);
        kind = (left < 3) ? BURST_FILL : (left < 6) ? BURST_DRAIN : BURST_MIX;
      end
      bursts++;
      pmode = $urandom_range(0, 3);
      pbase = $urandom_range(0, 1016);
      bias = $urandom_range(30, 70);
      case (kind)
        BURST_FILL:  left = QUEUE_DEPTH - gen_occ + $urandom_range(1, 3);
        BURST_DRAIN: left = gen_occ + $urandom_range(1, 2);
        default:     left = $urandom_range(8, 40);
      endcase
      if (left > TOTAL_ITEMS - n_items) left = TOTAL_ITEMS - n_items;
      repeat (left) begin
        if (kind == BURST_FILL) act = ACT_INSERT;
        else if (kind == BURST_DRAIN) act = ACT_REMOVE;
        else act = ($urandom_range(0, 99) < bias) ? ACT_INSERT : ACT_REMOVE;
        case (pmode)
          0:       pr = $urandom_range(0, 1023);
          1:       pr = $urandom_range(0, 3);
          2:       pr = $urandom_range(1020, 1023);
          default: pr = pbase + $urandom_range(0, 7);
        endcase
        add_item(act, pr, $urandom_range(0, 65535));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || start) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d inserts, %0d full rejects, %0d removes, %0d empty",
             n_inserted + n_full + n_removed + n_empty, n_inserted, n_full, n_removed,
             n_empty);
    $display("Peak occupancy %0d of %0d, %0d removes decided among equal priorities",
             peak_occ, QUEUE_DEPTH, n_ties);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
